[design/lz_token_decompressor_assert.svh]
// Assertion macros shared by the checker of the token decompressor.
`ifndef LZ_TOKEN_DECOMPRESSOR_ASSERT_SVH
`define LZ_TOKEN_DECOMPRESSOR_ASSERT_SVH

// Implication in the same cycle, checked at every rising edge out of reset.
`define LZTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent holds.
`define LZTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/lztd_pkg.sv]
// Package with the shared types and constants of the token decompressor.
`default_nettype none

package lztd_pkg;

    localparam logic [7:0] TOK_LIT_EXT1 = 8'h1d;
    localparam logic [7:0] TOK_LIT_EXT2 = 8'h1e;
    localparam logic [7:0] TOK_LIT_EXT4 = 8'h1f;
    localparam logic [7:0] TOK_HIGH_MIN = 8'h80;
    localparam logic [7:0] CLS_MASK     = 8'h60;
    localparam logic [7:0] CLS_SHORT    = 8'h20;
    localparam logic [7:0] CLS_OFF8     = 8'h40;
    localparam logic [7:0] MLEN_CODE2   = 8'hfe;
    localparam logic [7:0] MLEN_CODE4   = 8'hff;
    localparam logic [31:0] BIAS_EXT1   = 32'h1e;
    localparam logic [31:0] BIAS_EXT2   = 32'h11e;
    localparam logic [31:0] BIAS_MLEN2  = 32'h102;

    typedef enum logic [2:0] {
        TK_LIT_SHORT,
        TK_LIT_EXT1,
        TK_LIT_EXT2,
        TK_LIT_EXT4,
        TK_REF_SHORT,
        TK_REF_OFF8,
        TK_REF_LONG,
        TK_REF_HIGH
    } t_tok_kind;

    typedef struct packed {
        logic      mode;
        logic [7:0] in_byte;
        logic      start_stream;
        t_tok_kind kind;
    } t_item;

    typedef enum logic [3:0] {
        PH_TOKEN     = 4'd0,
        PH_LITERAL   = 4'd1,
        PH_LITLEN1   = 4'd2,
        PH_LITLEN2   = 4'd3,
        PH_LITLEN3   = 4'd4,
        PH_LITLEN4   = 4'd5,
        PH_OFF_SHORT = 4'd6,
        PH_OFF_LONG  = 4'd7,
        PH_OFF_HIGH  = 4'd8,
        PH_MLEN_CODE = 4'd9,
        PH_MLEN1     = 4'd10,
        PH_MLEN2     = 4'd11,
        PH_MLEN3     = 4'd12,
        PH_MLEN4     = 4'd13
    } t_phase;

    typedef enum logic [2:0] {
        ES_IDLE,
        ES_DEC,
        ES_DSET,
        ES_RD,
        ES_WR
    } t_eng_state;

    typedef struct packed {
        logic       err;
        logic       done_res;
        logic       more_pending;
        logic       last;
        logic [7:0] out_byte;
    } t_result;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    function automatic t_tok_kind classify(input logic [7:0] b);
        t_tok_kind k;
        if (b < TOK_LIT_EXT1) begin
            k = TK_LIT_SHORT;
        end else if (b == TOK_LIT_EXT1) begin
            k = TK_LIT_EXT1;
        end else if (b == TOK_LIT_EXT2) begin
            k = TK_LIT_EXT2;
        end else if (b == TOK_LIT_EXT4) begin
            k = TK_LIT_EXT4;
        end else if (b >= TOK_HIGH_MIN) begin
            k = TK_REF_HIGH;
        end else if ((b & CLS_MASK) == CLS_SHORT) begin
            k = TK_REF_SHORT;
        end else if ((b & CLS_MASK) == CLS_OFF8) begin
            k = TK_REF_OFF8;
        end else begin
            k = TK_REF_LONG;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[design/lztd_front.sv]
// Input queue that takes stream transfers and classifies each token byte.
`default_nettype none

module lztd_front
    import lztd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire logic   i_mode,
    input  wire logic [7:0] i_byte,
    input  wire logic   i_start,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_item       o_item
);

    t_item       r_buf [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_buf[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= '{mode: i_mode, in_byte: i_byte, start_stream: i_start,
                             kind: classify(i_byte)};
        end
    end

endmodule

`default_nettype wire

[design/lztd_engine.sv]
// Token parser, history window and copy engine with the result register.
`default_nettype none

module lztd_engine
    import lztd_pkg::*;
#(
    parameter int WINDOW_BYTES = 8192,
    parameter int BURST = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_len,
    input  wire logic        i_q_valid,
    output logic             o_q_ready,
    input  wire t_item       i_q_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_result          o_res
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int SW = AW + 2;
    localparam int CW = $clog2(BURST + 1);

    t_eng_state   r_state, n_state;
    t_item        r_item, n_item;
    t_phase       r_phase, n_phase;
    logic [31:0]  r_produced, n_produced;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [7:0]   r_token, n_token;
    logic [31:0]  r_acc, n_acc;
    logic [31:0]  r_rem, n_rem;
    logic [13:0]  r_dist, n_dist;
    logic         r_inlit, n_inlit;
    logic [CW-1:0] r_cnt, n_cnt;
    logic         r_more, n_more;
    logic         r_out_valid, n_out_valid;
    t_result      r_res;

    logic [7:0]   r_mem [WINDOW_BYTES];
    logic [7:0]   r_rd_data;
    logic [AW-1:0] rd_addr;
    logic         mem_we;
    logic [7:0]   mem_wdata;

    logic         out_free, emit;
    t_result      e_res;
    logic         done_now;
    logic [31:0]  pb_cnt;
    logic         pb_done;
    logic [AW-1:0] wptr_inc;
    logic [SW-1:0] wp_x, dist_x;
    logic [31:0]  left, nmin, acc_new;
    logic         sm, sl;
    logic [31:0]  sm_len, sl_len, rem_dec;
    logic [13:0]  sm_dist;
    logic [7:0]   b, t;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_res    = r_res;
    assign done_now = (r_produced >= i_len);
    assign pb_cnt   = r_produced + 32'd1;
    assign pb_done  = (pb_cnt >= i_len);
    assign wptr_inc = (r_wptr == AW'(WINDOW_BYTES - 1)) ? '0 : r_wptr + AW'(1);
    assign wp_x     = SW'(r_wptr);
    assign dist_x   = SW'(r_dist);
    assign rd_addr  = (wp_x >= dist_x) ? AW'(wp_x - dist_x)
                                       : AW'(wp_x + SW'(WINDOW_BYTES) - dist_x);
    assign left     = i_len - r_produced;
    assign b        = r_item.in_byte;
    assign t        = r_token;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_wptr] <= mem_wdata;
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state; n_item = r_item; n_phase = r_phase;
        n_produced = r_produced; n_wptr = r_wptr; n_token = r_token;
        n_acc = r_acc; n_rem = r_rem; n_dist = r_dist; n_inlit = r_inlit;
        n_cnt = r_cnt; n_more = r_more;
        n_out_valid = r_out_valid && !i_ready;
        o_q_ready = 1'b0;
        emit = 1'b0;
        e_res = '0;
        mem_we = 1'b0;
        mem_wdata = b;
        sm = 1'b0; sl = 1'b0;
        sm_len = '0; sl_len = '0; sm_dist = '0;
        acc_new = {r_acc[23:0], b};
        rem_dec = r_rem - 32'd1;
        nmin = (r_rem < left) ? r_rem : left;
        if (nmin > 32'(BURST)) nmin = 32'(BURST);

        unique case (r_state)
            ES_IDLE: begin
                if (i_q_valid) begin
                    o_q_ready = 1'b1;
                    n_item = i_q_item;
                    if (i_q_item.start_stream) begin
                        n_produced = '0; n_wptr = '0; n_phase = PH_TOKEN;
                        n_token = '0; n_acc = '0; n_rem = '0; n_dist = '0;
                        n_inlit = 1'b0;
                    end
                    n_state = ES_DEC;
                end
            end
            ES_DEC: begin
                if (out_free) begin
                    n_state = ES_IDLE;
                    if (r_item.mode || (r_rem != 0 && !r_inlit)) begin
                        n_state = ES_DSET;
                    end else if (done_now) begin
                        emit = 1'b1;
                        e_res = '{err: 1'b1, done_res: 1'b1, more_pending: 1'b0,
                                  last: 1'b1, out_byte: 8'd0};
                    end else if (r_phase == PH_LITERAL && r_inlit) begin
                        n_rem = rem_dec;
                        if (rem_dec == 0) begin
                            n_inlit = 1'b0;
                            n_phase = PH_TOKEN;
                        end
                        mem_we = 1'b1;
                        n_produced = pb_cnt;
                        n_wptr = wptr_inc;
                        if (pb_done) begin
                            n_rem = '0; n_inlit = 1'b0; n_phase = PH_TOKEN;
                        end
                        emit = 1'b1;
                        e_res = '{err: 1'b0, done_res: pb_done, more_pending: 1'b0,
                                  last: 1'b1, out_byte: b};
                    end else begin
                        unique case (r_phase) inside
                            PH_LITLEN1, PH_LITLEN2, PH_LITLEN3, PH_LITLEN4: begin
                                n_acc = acc_new;
                                if (r_phase == PH_LITLEN1) begin
                                    sl = 1'b1;
                                    sl_len = sat_add(acc_new, (t == TOK_LIT_EXT1) ? BIAS_EXT1 :
                                                     (t == TOK_LIT_EXT2) ? BIAS_EXT2 : 32'd0);
                                end else begin
                                    n_phase = t_phase'(r_phase - 4'd1);
                                end
                            end
                            PH_OFF_SHORT: begin
                                sm = 1'b1;
                                sm_dist = 14'(b) + 14'd1;
                                sm_len = 32'(t[4:0]) + 32'd7;
                            end
                            PH_OFF_LONG: begin
                                n_dist = {1'b0, t[4:0], b} + 14'd1;
                                n_phase = PH_MLEN_CODE;
                            end
                            PH_OFF_HIGH: begin
                                sm = 1'b1;
                                sm_dist = {1'b0, t[4:0], b} + 14'd1;
                                sm_len = 32'(t[6:5]) + 32'd3;
                            end
                            PH_MLEN_CODE: begin
                                n_token = b;
                                n_acc = '0;
                                if (b == MLEN_CODE2) begin
                                    n_phase = PH_MLEN2;
                                end else if (b == MLEN_CODE4) begin
                                    n_phase = PH_MLEN4;
                                end else begin
                                    sm = 1'b1;
                                    sm_dist = r_dist;
                                    sm_len = 32'(b) + 32'd7;
                                end
                            end
                            PH_MLEN1, PH_MLEN2, PH_MLEN3, PH_MLEN4: begin
                                n_acc = acc_new;
                                if (r_phase == PH_MLEN1) begin
                                    sm = 1'b1;
                                    sm_dist = r_dist;
                                    sm_len = sat_add(acc_new, ((t == MLEN_CODE2) ? BIAS_MLEN2
                                                               : 32'd0) + 32'd3);
                                end else begin
                                    n_phase = t_phase'(r_phase - 4'd1);
                                end
                            end
                            default: begin
                                n_token = b;
                                n_acc = '0;
                                n_inlit = 1'b0;
                                unique case (r_item.kind)
                                    TK_LIT_SHORT: begin
                                        sl = 1'b1;
                                        sl_len = 32'(b) + 32'd1;
                                    end
                                    TK_LIT_EXT1:  n_phase = PH_LITLEN1;
                                    TK_LIT_EXT2:  n_phase = PH_LITLEN2;
                                    TK_LIT_EXT4:  n_phase = PH_LITLEN4;
                                    TK_REF_SHORT: begin
                                        sm = 1'b1;
                                        sm_dist = 14'(b[4:2]) + 14'd1;
                                        sm_len = 32'(b[1:0]) + 32'd3;
                                    end
                                    TK_REF_OFF8:  n_phase = PH_OFF_SHORT;
                                    TK_REF_LONG:  n_phase = PH_OFF_LONG;
                                    TK_REF_HIGH:  n_phase = PH_OFF_HIGH;
                                    default:      n_phase = PH_TOKEN;
                                endcase
                            end
                        endcase
                        if (sl) begin
                            n_rem = sl_len;
                            n_inlit = (sl_len != 0);
                            n_phase = (sl_len != 0) ? PH_LITERAL : PH_TOKEN;
                        end
                        if (sm) begin
                            n_phase = PH_TOKEN;
                            n_dist = sm_dist;
                            if (32'(sm_dist) > r_produced) begin
                                n_rem = '0;
                                emit = 1'b1;
                                e_res = '{err: 1'b1, done_res: 1'b0, more_pending: 1'b0,
                                          last: 1'b1, out_byte: 8'd0};
                            end else begin
                                n_rem = sm_len;
                                n_state = ES_DSET;
                            end
                        end
                    end
                end
            end
            ES_DSET: begin
                if (done_now || r_rem == 0) begin
                    if (done_now) n_rem = '0;
                    n_state = ES_IDLE;
                end else begin
                    n_cnt = CW'(nmin);
                    n_more = (nmin != left) && (r_rem != nmin) && !r_inlit;
                    n_state = ES_RD;
                end
            end
            ES_RD: begin
                n_state = ES_WR;
            end
            ES_WR: begin
                if (out_free) begin
                    mem_we = 1'b1;
                    mem_wdata = r_rd_data;
                    n_produced = pb_cnt;
                    n_wptr = wptr_inc;
                    n_rem = rem_dec;
                    if (pb_done) begin
                        n_rem = '0; n_inlit = 1'b0; n_phase = PH_TOKEN;
                    end
                    n_cnt = r_cnt - CW'(1);
                    emit = 1'b1;
                    e_res = '{err: 1'b0, done_res: pb_done, more_pending: r_more,
                              last: (r_cnt == CW'(1)), out_byte: r_rd_data};
                    n_state = (r_cnt == CW'(1)) ? ES_IDLE : ES_RD;
                end
            end
            default: n_state = ES_IDLE;
        endcase
        if (emit) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
            r_phase <= PH_TOKEN;
            r_produced <= '0;
            r_wptr <= '0;
            r_token <= '0;
            r_acc <= '0;
            r_rem <= '0;
            r_dist <= '0;
            r_inlit <= 1'b0;
            r_cnt <= '0;
            r_more <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_produced <= n_produced;
            r_wptr <= n_wptr;
            r_token <= n_token;
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_dist <= n_dist;
            r_inlit <= n_inlit;
            r_cnt <= n_cnt;
            r_more <= n_more;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (emit) r_res <= e_res;
    end

endmodule

`default_nettype wire

[design/lz_token_decompressor.sv]
// Top level of the LZ77-style token decompressor.
// Compressed bytes enter a two-entry input queue and are decoded one at a time by the
// engine. An item that causes no result or a single literal or error result passes the
// engine through its queue pop and decode states, and its result is then held in the
// result register. A match item adds a setup state, and each byte of the copy passes a
// history window read state and then a write and result state; an item copies a burst
// of up to BURST bytes before the engine takes the next item. The window memory has no
// reset and needs no clearing pass. A full result register stalls the engine, while the
// input queue keeps taking transfers until it fills.
`default_nettype none

module lz_token_decompressor
    import lztd_pkg::*;
#(
    parameter int WINDOW_BYTES = 8192,
    parameter int BURST = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,      // output_length
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // in_byte
    input  wire logic [1:0]  s_axis_tuser,    // mode, start_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // out_byte
    output logic             m_axis_tlast,
    output logic [2:0]       m_axis_tuser     // more_pending, done_res, error
);

    logic [31:0] r_output_length;
    logic        q_valid, q_ready;
    t_item       q_item;
    t_result     res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_length <= '0;
        end else if (i_cfg_valid) begin
            r_output_length <= i_cfg_data;
        end
    end

    lztd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (s_axis_tuser[0]),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser[1]),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    lztd_engine #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .BURST        (BURST)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_len     (r_output_length),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_item  (q_item),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tdata = res.out_byte;
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = {res.err, res.done_res, res.more_pending};

endmodule

`default_nettype wire

[design/lztd_checker.sv]
// Port checker for the token decompressor and its bind to the top level.
`default_nettype none

`include "lz_token_decompressor_assert.svh"

module lztd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic [2:0] m_axis_tuser
);

    `LZTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Stalled result changed.")
    `LZTD_ASSERT_NOW(a_err_result, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast && m_axis_tdata == 8'd0, "Error result is not a lone zero byte.")
    `LZTD_ASSERT_NOW(a_err_no_pending, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], !m_axis_tuser[0], "Error result shows a pending copy.")

endmodule

bind lz_token_decompressor lztd_checker u_lztd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
